/* rtl/core/anpl_pkg.sv */
// Shared constants and types for the active note priority list.
package anpl_pkg;

  localparam int LIST_DEPTH = 128;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int NOTE_W     = 7;
  localparam int ACTION_W   = 2;
  localparam int COUNT_W    = 8;

  // Command codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

/* rtl/core/anpl_if.sv */
// Command and result channel interfaces for the active note priority list.
interface anpl_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [anpl_pkg::ACTION_W-1:0] action;
  logic [anpl_pkg::NOTE_W-1:0]   note;

  modport source (output valid, action, note, input ready);
  modport sink   (input valid, action, note, output ready);
endinterface

interface anpl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [anpl_pkg::NOTE_W-1:0]  newest_note;
  logic                         newest_valid;
  logic [anpl_pkg::COUNT_W-1:0] active_count;

  modport source (output valid, newest_note, newest_valid, active_count, input ready);
  modport sink   (input valid, newest_note, newest_valid, active_count, output ready);
endinterface

/* rtl/core/active_note_priority_list.sv */
// Last-note-priority list of active notes, walked one slot per cycle.
//
// Keeps up to 128 distinct notes, most recent first, in a dual-port slot
// memory. Each command transfer (insert, remove, clear) yields one result
// transfer with the front note, a valid flag and the note count after the
// command; the unused command code changes nothing and just reports. Insert
// and remove walk the valid slots one per cycle through the memory read
// port (insert stops early when it meets the note); clear and the unused
// code go straight to the result state.
// A command is taken only while the sequencer is idle; a finished result
// sits in the output register and does not hold off the next command.
module active_note_priority_list (
  input  logic       clk,
  input  logic       rst,
  anpl_cmd_if.sink   cmd,
  anpl_rsp_if.source rsp
);
  import anpl_pkg::*;

  state_t              state;
  logic [ACTION_W-1:0] act;
  logic [NOTE_W-1:0]   key;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    iss;
  logic                pv;
  logic [IDX_W-1:0]    pidx;
  logic [NOTE_W-1:0]   rd_data;
  logic [NOTE_W-1:0]   carry;
  logic [NOTE_W-1:0]   front;
  logic                stop;
  logic                found;

  logic [NOTE_W-1:0]   mem [LIST_DEPTH];

  logic                issue;
  logic                proc;
  logic                hit;
  logic                walk_done;
  logic                not_full;
  logic                we;
  logic [IDX_W-1:0]    wa;
  logic [NOTE_W-1:0]   wd;

  logic                rsp_valid;
  logic [NOTE_W-1:0]   rsp_note;
  logic                rsp_nvalid;
  logic [COUNT_W-1:0]  rsp_count;

  assign cmd.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.newest_note  = rsp_note;
  assign rsp.newest_valid = rsp_nvalid;
  assign rsp.active_count = rsp_count;

  // Walk control: read one slot a cycle, process it in the cycle after
  assign issue     = (state == S_WALK) && !stop && (iss < count);
  assign proc      = (state == S_WALK) && pv && !stop;
  assign hit       = (rd_data == key);
  assign walk_done = (state == S_WALK) && (stop || ((iss == count) && !pv));
  assign not_full  = (count < CNT_W'(LIST_DEPTH));

  // Slot write port: shift back on insert, shift forward on remove
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rd_data;
    if (proc) begin
      if (act == ACT_INSERT) begin
        we = 1'b1;
        wa = pidx;
        wd = carry;
      end else if (found) begin
        we = 1'b1;
        wa = pidx - IDX_W'(1);
        wd = rd_data;
      end
    end else if (walk_done && (act == ACT_INSERT) && !stop && not_full) begin
      // new note: the last carried entry lands in the first free slot
      we = 1'b1;
      wa = count[IDX_W-1:0];
      wd = carry;
    end
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_data <= mem[iss[IDX_W-1:0]];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (issue) begin
      pidx <= iss[IDX_W-1:0];
    end
    // mirror of slot zero for the result
    if (we && (wa == '0)) begin
      front <= wd;
    end
    if ((state == S_IDLE) && cmd.valid) begin
      act   <= cmd.action;
      key   <= cmd.note;
      carry <= cmd.note;
    end else if (proc && (act == ACT_INSERT)) begin
      carry <= rd_data;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      iss       <= '0;
      pv        <= 1'b0;
      stop      <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pv <= issue;
      if (issue) begin
        iss <= iss + CNT_W'(1);
      end
      // result leaves; when finishing, the new result is loaded below instead
      if (rsp_valid && rsp.ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            iss   <= '0;
            stop  <= 1'b0;
            found <= 1'b0;
            if ((cmd.action == ACT_INSERT) || (cmd.action == ACT_REMOVE)) begin
              state <= S_WALK;
            end else begin
              if (cmd.action == ACT_CLEAR) begin
                count <= '0;
              end
              state <= S_FINISH;
            end
          end
        end
        S_WALK: begin
          if (proc && hit) begin
            if (act == ACT_INSERT) begin
              stop <= 1'b1;
            end else begin
              found <= 1'b1;
            end
          end
          if (walk_done) begin
            if ((act == ACT_INSERT) && !stop && not_full) begin
              count <= count + CNT_W'(1);
            end else if ((act == ACT_REMOVE) && found) begin
              count <= count - CNT_W'(1);
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_note   <= (count != '0) ? front : '0;
            rsp_nvalid <= (count != '0);
            rsp_count  <= COUNT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/anpl_checker.sv */
// Scoreboard for the note priority list: mirrors the list and checks each result transfer.
module anpl_checker (
  input  logic clk,
  input  logic rst,
  anpl_cmd_if  cmd,
  anpl_rsp_if  rsp,
  output int   fail_count,
  output int   reports_due,
  output int   checked_count,
  output int   full_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import anpl_pkg::*;

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic               valid;
    logic [COUNT_W-1:0] count;
  } front_report_t;

  // Mirror of the list, most recent note at index 0
  logic [NOTE_W-1:0] held_notes [LIST_DEPTH];
  int                held_count;
  front_report_t     front_reports_q [$];

  function automatic int find_held(input logic [NOTE_W-1:0] n);
    for (int i = 0; i < held_count; i++)
      if (held_notes[i] == n) return i;
    return -1;
  endfunction

  // Apply one command to the mirror and return the report it should produce
  function automatic front_report_t apply_command(input logic [ACTION_W-1:0] act,
                                                  input logic [NOTE_W-1:0]   n);
    int            pos;
    front_report_t rep;
    pos = find_held(n);
    case (act)
      ACT_INSERT: begin
        // new note pushes everything back; when full the oldest falls off
        if (pos < 0) begin
          pos = (held_count < LIST_DEPTH) ? held_count : LIST_DEPTH - 1;
          if (held_count < LIST_DEPTH) held_count++;
        end
        for (int i = pos; i > 0; i--) held_notes[i] = held_notes[i-1];
        held_notes[0] = n;
      end
      ACT_REMOVE: begin
        // absent note: nothing moves
        if (pos >= 0) begin
          for (int i = pos; i + 1 < held_count; i++) held_notes[i] = held_notes[i+1];
          held_count--;
        end
      end
      ACT_CLEAR: held_count = 0;
      default: ;  // unused code only reports
    endcase
    rep.valid = (held_count != 0);
    rep.note  = rep.valid ? held_notes[0] : '0;
    rep.count = COUNT_W'(held_count);
    return rep;
  endfunction

  function automatic void check_field(input string              field,
                                      input logic [COUNT_W-1:0] want,
                                      input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Compare the result transfer first: it never belongs to a command taken on the same edge
  always @(posedge clk) begin
    front_report_t want;
    if (rst) begin
      held_count    = 0;
      fail_count    = 0;
      checked_count = 0;
      full_count    = 0;
      front_reports_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (front_reports_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer, expected none, %s %0d valid %0d count %0d",
                   $time, "actual note", rsp.newest_note, rsp.newest_valid,
                   rsp.active_count);
        end else begin
          want = front_reports_q.pop_front();
          checked_count++;
          if (want.count == LIST_DEPTH) full_count++;
          check_field("newest_note", want.note, rsp.newest_note);
          check_field("newest_valid", want.valid, rsp.newest_valid);
          check_field("active_count", want.count, rsp.active_count);
        end
      end
      if (cmd.valid && cmd.ready)
        front_reports_q.push_back(apply_command(cmd.action, cmd.note));
    end
    reports_due = front_reports_q.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import anpl_pkg::*;

  localparam int NOTE_RANGE   = 2 ** NOTE_W;
  localparam int TOTAL_ITEMS  = 1850;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE_WAIT  = 140;
  localparam int DRAIN_LIMIT  = 50_000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int reports_due;
  int checked_count;
  int full_count;
  int sent_by_action [4];
  int sent_total;
  int hold_asks;
  int cycles;
  bit quiet;

  anpl_cmd_if cmd_ch ();
  anpl_rsp_if rsp_ch ();

  active_note_priority_list i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  anpl_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .reports_due   (reports_due),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, reports_due);
      $display("FAIL active_note_priority_list");
      $finish;
    end
  end

  // One command transfer; called and returns at a falling edge, valid stays up between items but for random gaps
  task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [NOTE_W-1:0] n);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid  = 1'b1;
    cmd_ch.action = act;
    cmd_ch.note   = n;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent_by_action[act]++;
    sent_total++;
    @(negedge clk);
  endtask

  function automatic void shuffle_notes(output int order [NOTE_RANGE]);
    int j;
    int t;
    foreach (order[i]) order[i] = i;
    for (int i = NOTE_RANGE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endfunction

  // Result side: short stall bursts, calm stretches, and long hold-offs on request
  initial begin
    int stall_left;
    int calm_left;
    int hold_left;
    int hold_seen;
    stall_left   = 0;
    calm_left    = 0;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = $urandom_range(300, 500);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else if (quiet || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        rsp_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            stall_left   = $urandom_range(0, 4);
            rsp_ch.ready = 1'b0;
          end
          2: begin
            calm_left    = $urandom_range(20, 80);
            rsp_ch.ready = 1'b1;
          end
          default: rsp_ch.ready = 1'b1;
        endcase
      end
    end
  end

  // Command stimulus and verdict
  initial begin
    int                order [NOTE_RANGE];
    int                pick;
    int                roll;
    int                pool_base;
    int                pool_span;
    int                drain_cycles;
    logic [NOTE_W-1:0] n;
    cmd_ch.valid  = 1'b0;
    cmd_ch.action = ACT_INSERT;
    cmd_ch.note   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty-list cases, extremes, move to front, absent remove, clear, unused code
    send_cmd(ACT_REMOVE, 7'd5);
    send_cmd(ACT_UNUSED, 7'd0);
    send_cmd(ACT_CLEAR,  7'd127);
    send_cmd(ACT_INSERT, 7'd0);
    send_cmd(ACT_INSERT, 7'd127);
    send_cmd(ACT_INSERT, 7'd64);
    send_cmd(ACT_INSERT, 7'd0);
    send_cmd(ACT_INSERT, 7'd0);
    send_cmd(ACT_REMOVE, 7'd64);
    send_cmd(ACT_REMOVE, 7'd99);
    send_cmd(ACT_UNUSED, 7'd127);
    send_cmd(ACT_REMOVE, 7'd0);
    send_cmd(ACT_REMOVE, 7'd127);
    send_cmd(ACT_INSERT, 7'd42);
    send_cmd(ACT_CLEAR,  7'd127);
    send_cmd(ACT_INSERT, 7'd85);
    send_cmd(ACT_INSERT, 7'd42);
    send_cmd(ACT_INSERT, 7'd85);
    send_cmd(ACT_REMOVE, 7'd85);
    send_cmd(ACT_UNUSED, 7'd85);
    send_cmd(ACT_CLEAR,  7'd0);

    // Random segments; the first one runs against a long result hold-off
    hold_asks++;
    while (sent_total < TOTAL_ITEMS) begin
      quiet = (sent_total >= TOTAL_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 9);
      if (pick <= 1) begin
        // fill with every note in random order, then touch the full list
        shuffle_notes(order);
        foreach (order[i]) send_cmd(ACT_INSERT, NOTE_W'(order[i]));
        repeat ($urandom_range(3, 10))
          send_cmd(ACT_INSERT, NOTE_W'($urandom_range(0, NOTE_RANGE - 1)));
      end else if (pick == 2) begin
        // remove every note in random order
        shuffle_notes(order);
        foreach (order[i]) send_cmd(ACT_REMOVE, NOTE_W'(order[i]));
      end else if (pick == 8) begin
        // anything goes
        repeat ($urandom_range(10, 20))
          send_cmd(ACTION_W'($urandom_range(0, 3)), NOTE_W'($urandom_range(0, NOTE_RANGE - 1)));
      end else begin
        // churn over a small pool so removes and re-inserts mostly hit
        if (pick == 9 && !quiet) hold_asks++;
        pool_span = $urandom_range(4, 24);
        pool_base = $urandom_range(0, NOTE_RANGE - pool_span);
        repeat ($urandom_range(20, 60)) begin
          n    = NOTE_W'(pool_base + $urandom_range(0, pool_span - 1));
          roll = $urandom_range(0, 99);
          if (roll < 52)      send_cmd(ACT_INSERT, n);
          else if (roll < 92) send_cmd(ACT_REMOVE, n);
          else if (roll < 95) send_cmd(ACT_CLEAR, n);
          else if (roll < 97) send_cmd(ACT_UNUSED, n);
          else                send_cmd(ACT_REMOVE, NOTE_W'($urandom_range(0, NOTE_RANGE - 1)));
        end
      end
    end
    cmd_ch.valid = 1'b0;

    // Drain outstanding results, then watch for strays
    drain_cycles = 0;
    while (reports_due != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Sent %0d commands: %0d inserts, %0d removes, %0d clears, %0d unused codes.",
             sent_total, sent_by_action[ACT_INSERT], sent_by_action[ACT_REMOVE],
             sent_by_action[ACT_CLEAR], sent_by_action[ACT_UNUSED]);
    $display("Checked %0d results, %0d with the list full; %0d failures, %0d results missing.",
             checked_count, full_count, fail_count, reports_due);
    if (fail_count == 0 && reports_due == 0) begin
      $display("PASS active_note_priority_list");
    end else begin
      $display("FAIL active_note_priority_list");
    end
    $finish;
  end

endmodule
